[hw/rtl/nsr_pkg.sv]
// Package for the Newton-Raphson square root block.
// Holds field widths, register indexes, reset values and the sequencer state type.
// No dependencies.
package nsr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int RADICAND_W    = 32;
    localparam int ROOT_W        = 24;
    localparam int OUT_FRAC      = 16;
    localparam int Y_W           = 40;
    localparam int ITER_W        = 6;
    localparam int TOL_W         = 16;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;

    localparam logic [Y_W-1:0]    QUOT_CAP = {Y_W{1'b1}};
    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_TOLERANCE  = CFG_IDX_W'(1);

    localparam logic [ITER_W-1:0] ITER_COUNT_RST = ITER_W'(10);
    localparam logic [TOL_W-1:0]  TOLERANCE_RST  = TOL_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

endpackage

[hw/rtl/newton_square_root_top.sv]
// Top level of the Newton-Raphson square root block: stream ports, configuration
// registers, the iteration sequencer and its shared bit-serial divider.
// Depends on nsr_pkg.

// The block takes one unsigned radicand (FRAC_BITS fractional bits) per input
// transfer and returns its square root in unsigned Q8.16, saturated at the
// top of the range, plus a flag that says the iteration ended early because
// twice the estimate fell below the tolerance register. The start guess is
// x/2 for x above 1.0 and 1.0 otherwise; then up to iteration_count Newton
// steps y <- (y + x*2^FRAC_BITS/y)/2 run, truncating, with the quotient
// saturated at 2^40-1. One item is processed at a time and s_axis_tready is
// high only while the sequencer is idle. Each Newton step passes through the
// tolerance check, the restoring divider (one quotient bit per cycle through
// one shared 41-bit subtractor) and the update. The result sits in an output
// register, so a new radicand is taken while the previous result still waits
// for m_axis_tready. Configuration writes are accepted only while the
// sequencer is idle (o_cfg_ready follows s_axis_tready), so a write never
// changes the settings of an item in flight.
module newton_square_root_top
    import nsr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream. tdata: radicand[31:0].
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [RADICAND_W-1:0]  s_axis_tdata,
    // Output stream. tdata: root[23:0]. tuser: stopped_early[0].
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [ROOT_W-1:0]      m_axis_tdata,
    output logic                   m_axis_tuser,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // The dividend x * 2^FRAC_BITS is fed to the divider MSB first.
    localparam int DVD_W = RADICAND_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int WIDE_W = Y_W + OUT_FRAC;

    localparam logic [Y_W-1:0] ONE_Y = Y_W'(1) << FRAC_BITS;

    // Control registers.
    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic [ITER_W-1:0]   r_iter_count, n_iter_count;
    logic [TOL_W-1:0]    r_tolerance, n_tolerance;

    // Datapath registers.
    logic [RADICAND_W-1:0] r_x, n_x;
    logic [Y_W-1:0]        r_y, n_y;
    logic [Y_W-1:0]        r_rem, n_rem;
    logic [Y_W-1:0]        r_quot, n_quot;
    logic                  r_quot_ovf, n_quot_ovf;
    logic [DVD_W-1:0]      r_dvd, n_dvd;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [ITER_W-1:0]     r_iter, n_iter;
    logic                  r_flag, n_flag;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic                  r_stop, n_stop;

    // Shared subtractor and helpers.
    logic [Y_W:0]     rem_shift;
    logic [Y_W+1:0]   diff;
    logic             borrow;
    logic [Y_W-1:0]   quot_sat;
    logic [Y_W:0]     sum;
    logic [Y_W:0]     twice_y;
    logic [WIDE_W-1:0] wide_root;
    logic             in_xfer;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_root;
    assign m_axis_tuser  = r_stop;

    assign rem_shift = {r_rem, r_dvd[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, r_y};
    assign borrow    = diff[Y_W+1];
    assign quot_sat  = r_quot_ovf ? QUOT_CAP : r_quot;
    assign sum       = {1'b0, r_y} + {1'b0, quot_sat};
    assign twice_y   = {r_y, 1'b0};
    // Rescale to 16 fractional bits, truncating, for any FRAC_BITS.
    assign wide_root = {r_y, {OUT_FRAC{1'b0}}} >> FRAC_BITS;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_iter_count = r_iter_count;
        n_tolerance  = r_tolerance;
        n_x          = r_x;
        n_y          = r_y;
        n_rem        = r_rem;
        n_quot       = r_quot;
        n_quot_ovf   = r_quot_ovf;
        n_dvd        = r_dvd;
        n_cnt        = r_cnt;
        n_iter       = r_iter;
        n_flag       = r_flag;
        n_root       = r_root;
        n_stop       = r_stop;

        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_ITERATION_COUNT) begin
                n_iter_count = i_cfg_data[ITER_W-1:0];
            end else if (i_cfg_index == REG_DERIVATIVE_TOLERANCE) begin
                n_tolerance = i_cfg_data[TOL_W-1:0];
            end
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_x    = s_axis_tdata;
                    n_iter = '0;
                    n_flag = 1'b0;
                    if ({{(Y_W-RADICAND_W){1'b0}}, s_axis_tdata} > ONE_Y) begin
                        n_y = {{(Y_W-RADICAND_W+1){1'b0}}, s_axis_tdata[RADICAND_W-1:1]};
                    end else begin
                        n_y = ONE_Y;
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_iter == r_iter_count) begin
                    n_state = ST_FINISH;
                end else if (twice_y < {{(Y_W+1-TOL_W){1'b0}}, r_tolerance}) begin
                    n_flag  = 1'b1;
                    n_state = ST_FINISH;
                end else if (r_y == '0) begin
                    // A zero estimate is held; no division is attempted.
                    n_state = ST_FINISH;
                end else begin
                    n_dvd      = {r_x, {FRAC_BITS{1'b0}}};
                    n_rem      = '0;
                    n_quot     = '0;
                    n_quot_ovf = 1'b0;
                    n_cnt      = CNT_W'(DVD_W);
                    n_state    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                n_dvd      = {r_dvd[DVD_W-2:0], 1'b0};
                n_rem      = borrow ? rem_shift[Y_W-1:0] : diff[Y_W-1:0];
                n_quot     = {r_quot[Y_W-2:0], !borrow};
                n_quot_ovf = r_quot_ovf | r_quot[Y_W-1];
                n_cnt      = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_y     = sum[Y_W:1];
                n_iter  = r_iter + ITER_W'(1);
                n_state = ST_CHECK;
            end
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    if (wide_root > {{(WIDE_W-ROOT_W){1'b0}}, ROOT_MAX}) begin
                        n_root = ROOT_MAX;
                    end else begin
                        n_root = wide_root[ROOT_W-1:0];
                    end
                    n_stop      = r_flag;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_iter_count <= ITER_COUNT_RST;
            r_tolerance  <= TOLERANCE_RST;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_iter_count <= n_iter_count;
            r_tolerance  <= n_tolerance;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
        r_quot_ovf <= n_quot_ovf;
        r_dvd      <= n_dvd;
        r_cnt      <= n_cnt;
        r_iter     <= n_iter;
        r_flag     <= n_flag;
        r_root     <= n_root;
        r_stop     <= n_stop;
    end

`ifndef SYNTHESIS
    // The partial remainder always stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_rem < r_y))
        else $error("divider remainder not below divisor");

    // The divider never runs on a zero estimate.
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_y != '0))
        else $error("division by a zero estimate");

    // Every update advances the step counter by exactly one.
    a_iter_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> (r_iter == $past(r_iter) + ITER_W'(1)))
        else $error("step counter did not advance on update");

    // A result appears only when the sequencer finishes an item.
    a_valid_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result valid raised outside finish");
`endif

endmodule

[test/tb_newton_square_root_top.sv]
// Testbench for newton_square_root_top: drives radicands and configuration writes,
// predicts every root and early-stop flag, and checks the output stream in order.
// Depends on nsr_pkg and the newton_square_root_top RTL.
module tb_newton_square_root_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nsr_pkg::*;

    // Items with 63 Newton steps take longest. The stimulus keeps most phases at
    // 16 steps or fewer, and the limit bounds the whole run.
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES   = 3200;
    localparam int RANDOM_PHASES   = 9;
    localparam int PHASE_ITEMS     = 46;
    localparam int LONG_PHASE      = 4;
    localparam int LONG_ITEMS      = 10;
    localparam int ONE_STEP_PHASE  = 7;

    // Indexes that name no register. Writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              stopped_early;
    } t_root_result;

    // Keeps a private copy of the two registers, computes the expected root for
    // every accepted radicand and compares the output stream against it.
    class root_tracker;
        logic [ITER_W-1:0] step_limit;
        logic [TOL_W-1:0]  tolerance;
        t_root_result      expected_roots[$];
        int                errors;

        function new();
            step_limit = ITER_COUNT_RST;
            tolerance  = TOLERANCE_RST;
            errors     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ITERATION_COUNT) begin
                step_limit = data[ITER_W-1:0];
            end else if (idx == REG_DERIVATIVE_TOLERANCE) begin
                tolerance = data[TOL_W-1:0];
            end
        endfunction

        // Newton iteration written as y <- (y + x*2^F/y)/2 with truncation. The
        // quotient fits in 64 bits because x*2^16 stays below 2^48.
        function t_root_result compute_root(logic [RADICAND_W-1:0] x);
            logic [63:0]  one;
            logic [63:0]  y;
            logic [63:0]  quotient;
            logic         stopped;
            logic         done;
            int unsigned  step;
            t_root_result res;
            one     = 64'(1) << FRAC_BITS_DEF;
            y       = (64'(x) > one) ? 64'(x >> 1) : one;
            stopped = 1'b0;
            done    = 1'b0;
            step    = 0;
            while (!done && step < step_limit) begin
                if ((y << 1) < 64'(tolerance)) begin
                    stopped = 1'b1;
                    done    = 1'b1;
                end else if (y == 0) begin
                    // A zero estimate is held; only x = 0 with zero tolerance gets here.
                    done = 1'b1;
                end else begin
                    quotient = (64'(x) << FRAC_BITS_DEF) / y;
                    if (quotient > 64'(QUOT_CAP)) begin
                        quotient = 64'(QUOT_CAP);
                    end
                    y = (y + quotient) >> 1;
                    step++;
                end
            end
            res.root          = (y > 64'(ROOT_MAX)) ? ROOT_MAX : y[ROOT_W-1:0];
            res.stopped_early = stopped;
            return res;
        endfunction

        function void note_radicand(logic [RADICAND_W-1:0] x);
            expected_roots.push_back(compute_root(x));
        endfunction

        function void check_result(logic [ROOT_W-1:0] root, logic flag);
            t_root_result want;
            if (expected_roots.size() == 0) begin
                $display("%0t: unexpected result, root %h flag %b", $time, root, flag);
                errors++;
                return;
            end
            want = expected_roots.pop_front();
            if (want.root !== root) begin
                $display("%0t: root mismatch, expected %h actual %h",
                         $time, want.root, root);
                errors++;
            end
            if (want.stopped_early !== flag) begin
                $display("%0t: stopped_early mismatch, expected %b actual %b",
                         $time, want.stopped_early, flag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_roots.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [RADICAND_W-1:0] s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [ROOT_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    root_tracker tracker = new();
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          cycle_count = 0;

    newton_square_root_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver drops tready at random. Since the result sits in an output
    // register while the next radicand is already being worked on, these stalls
    // overlap every stage of the iteration.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // All testbench drivers use nonblocking assignments, so this block sees the
    // values from before the edge, the same ones the block itself sees.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // A hung handshake is caught here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One radicand transfer. The sender may idle first. tvalid is left high
    // afterwards, so back-to-back transfers need only one assignment per edge.
    task automatic send_radicand(logic [RADICAND_W-1:0] x);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        tracker.note_radicand(x);
    endtask

    // The sender holds off until every outstanding root has come back. Each
    // radicand yields exactly one result, so the block is idle after that.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // cfg_valid stays high between consecutive writes. The caller lowers it.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        tracker.set_register(idx, data);
    endtask

    // The upper bits of the iteration count write are random. Only the low
    // six bits form the register.
    task automatic set_config(logic [ITER_W-1:0] steps, logic [TOL_W-1:0] tol_value);
        logic [CFG_DATA_W-1:0] count_word;
        count_word = CFG_DATA_W'($urandom);
        count_word[ITER_W-1:0] = steps;
        write_register(REG_ITERATION_COUNT, count_word);
        write_register(REG_DERIVATIVE_TOLERANCE, CFG_DATA_W'(tol_value));
        i_cfg_valid <= 1'b0;
    endtask

    // Mix of full-range values, values around 1.0, values of random magnitude
    // and values below 256.0, so both the x/2 and the 1.0 start guesses are common.
    function automatic logic [RADICAND_W-1:0] pick_radicand();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0002_0000);
            2:       return $urandom >> $urandom_range(0, 31);
            default: return {16'($urandom_range(0, 255)), 16'($urandom)};
        endcase
    endfunction

    function automatic logic [TOL_W-1:0] pick_tolerance();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return TOL_W'(1);
            2:       return {TOL_W{1'b1}};
            3:       return TOL_W'($urandom_range(0, 1023));
            default: return TOL_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [ITER_W-1:0] steps;
        int                items;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register reset values: ten steps, tolerance 1. Covers zero, the
        // smallest nonzero value, both sides of exactly 1.0, small powers of
        // two, and the top of the range where the output saturates.
        send_radicand(32'h0000_0000);
        send_radicand(32'h0000_0001);
        send_radicand(32'h0000_FFFF);
        send_radicand(32'h0001_0000);
        send_radicand(32'h0001_0001);
        send_radicand(32'h0002_0000);
        send_radicand(32'h0004_0000);
        send_radicand(32'h8000_0000);
        send_radicand(32'hFFFF_FFFF);
        send_radicand(32'h5555_5555);
        send_radicand(32'hAAAA_AAAA);
        drain_results();

        // No steps at all: the root is the start guess, saturated when large.
        set_config('0, '0);
        send_radicand(32'h1234_5678);
        send_radicand(32'h0000_8000);
        drain_results();

        // Maximum steps with zero tolerance. A zero radicand halves the estimate
        // down to zero, where it is held without raising the flag.
        set_config({ITER_W{1'b1}}, '0);
        send_radicand(32'h0000_0000);
        send_radicand(32'hFFFF_FFFF);
        send_radicand(32'h0000_0001);
        drain_results();

        // Largest tolerance: small radicands stop early once 2y falls below it.
        set_config({ITER_W{1'b1}}, {TOL_W{1'b1}});
        send_radicand(32'h0000_0001);
        send_radicand(32'h0000_0100);
        send_radicand(32'hFFFF_FFFF);
        drain_results();

        // Writes to indexes with no register behind them must leave both
        // registers unchanged.
        write_register(REG_SPARE, CFG_DATA_W'($urandom));
        write_register(REG_LAST_INDEX, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;

        // Random phases with a new setting each. First the sender idles less
        // than the receiver, then the other way round, then neither idles.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 3) begin
                tx_idle_pct = 36;
                rx_idle_pct = 70;
            end else if (phase < 6) begin
                tx_idle_pct = 70;
                rx_idle_pct = 36;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase == LONG_PHASE) begin
                steps = {ITER_W{1'b1}};
            end else if (phase == ONE_STEP_PHASE) begin
                steps = ITER_W'(1);
            end else begin
                steps = ITER_W'($urandom_range(0, 16));
            end
            set_config(steps, pick_tolerance());
            items = (phase == LONG_PHASE) ? LONG_ITEMS : PHASE_ITEMS;
            for (int n = 0; n < items; n++) begin
                send_radicand(pick_radicand());
            end
            drain_results();
        end

        // Allow one full item of latency for any stray result to show up.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
